FILE: sv/mhp_pkg.sv
// Shared types, codes and helper functions for the MAC header parser.
// No dependencies; every other file of the block imports this package.
package mhp_pkg;

	localparam int MHP_MAX_FRAME_BYTES = 127;

	// Byte position counter; it saturates at its top value.
	localparam int IDX_W = 7;
	localparam logic [IDX_W-1:0] IDX_SAT = 7'd127;

	// Header length holds up to 3 + 2 + 8 + 2 + 8 = 23 bytes.
	localparam int HL_W = 5;
	localparam logic [HL_W-1:0] BASE_HDR_BYTES = 5'd3;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_SHORT   = 2'd2
	} kind_t;

	localparam logic [2:0] FT_BEACON = 3'd0;
	localparam logic [2:0] FT_DATA   = 3'd1;
	localparam logic [2:0] FT_CMD    = 3'd3;

	localparam logic [1:0] AM_SHORT = 2'd2;
	localparam logic [1:0] AM_EXT   = 2'd3;

	localparam int CW_PAN_COMP_BIT = 6;

	typedef struct packed {
		logic [3:0] dp;
		logic [3:0] dl;
		logic [3:0] sp;
		logic [3:0] sl;
	} sizes_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic [7:0] link_quality;
	} beat_t;

	typedef struct packed {
		kind_t       item_kind;
		logic [2:0]  fc_type;
		logic [1:0]  dst_addr_mode;
		logic [1:0]  src_addr_mode;
		logic [5:0]  control_flags;
		logic [15:0] dest_pan;
		logic [63:0] dest_addr;
		logic [15:0] source_pan;
		logic [63:0] source_addr;
		logic [7:0]  payload_byte;
		logic        frame_end;
		logic [7:0]  quality_out;
	} result_t;

	typedef struct packed {
		logic    emit;
		result_t fields;
	} parse_res_t;

	function automatic logic [3:0] addr_bytes(input logic [1:0] mode);
		logic [3:0] n;
		unique case (mode)
			AM_SHORT: n = 4'd2;
			AM_EXT:   n = 4'd8;
			default:  n = 4'd0;
		endcase
		return n;
	endfunction

	// Sizes of the four addressing fields as the frame control word gives them.
	function automatic sizes_t field_sizes(input logic [15:0] cw);
		sizes_t s;
		s = '0;
		if (cw[2:0] == FT_BEACON || cw[2:0] == FT_DATA || cw[2:0] == FT_CMD) begin
			s.dl = addr_bytes(cw[11:10]);
			s.dp = (s.dl != 4'd0) ? 4'd2 : 4'd0;
			s.sl = addr_bytes(cw[15:14]);
			s.sp = (s.sl != 4'd0 && !cw[CW_PAN_COMP_BIT]) ? 4'd2 : 4'd0;
		end
		return s;
	endfunction

endpackage

FILE: sv/mhp_if.sv
// Stream interfaces for the MAC header parser: received bytes in, results out.
// Depends on mhp_pkg.
interface mhp_in_if;
	import mhp_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic [7:0] link_quality;

	modport source (output valid, data_byte, last_byte, link_quality, input ready);
	modport sink (input valid, data_byte, last_byte, link_quality, output ready);
endinterface

interface mhp_out_if;
	import mhp_pkg::*;

	logic        valid;
	logic        ready;
	kind_t       item_kind;
	logic [2:0]  fc_type;
	logic [1:0]  dst_addr_mode;
	logic [1:0]  src_addr_mode;
	logic [5:0]  control_flags;
	logic [15:0] dest_pan;
	logic [63:0] dest_addr;
	logic [15:0] source_pan;
	logic [63:0] source_addr;
	logic [7:0]  payload_byte;
	logic        frame_end;
	logic [7:0]  quality_out;

	modport source (output valid, item_kind, fc_type, dst_addr_mode, src_addr_mode,
		control_flags, dest_pan, dest_addr, source_pan, source_addr, payload_byte,
		frame_end, quality_out, input ready);
	modport sink (input valid, item_kind, fc_type, dst_addr_mode, src_addr_mode,
		control_flags, dest_pan, dest_addr, source_pan, source_addr, payload_byte,
		frame_end, quality_out, output ready);
endinterface

FILE: sv/mac_header_parser.sv
// MAC header parser: one received frame byte per beat in, at most one result per beat out.
// A byte passes the input register, then the parse logic and the output register.
// Throughput: one byte per cycle unless the output stalls; the parse result lands in
// the output register, so a stalled output holds one beat there.
// Reset (arst_n, asynchronous): both registers empty, byte position zero, header cleared.
// Depends on mhp_pkg, mhp_if and mhp_parse.
module mac_header_parser #(
	parameter int MAX_FRAME_BYTES = mhp_pkg::MHP_MAX_FRAME_BYTES
) (
	input logic      clk,
	input logic      arst_n,
	mhp_in_if.sink   rx,
	mhp_out_if.source res
);
	import mhp_pkg::*;

	beat_t      beat_s1;
	logic       valid_s1;
	result_t    res_q;
	logic       res_valid_q;
	logic       out_free, adv_s1;
	parse_res_t pr;

	assign out_free = !res_valid_q || res.ready;
	assign adv_s1   = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			beat_s1.data_byte    <= rx.data_byte;
			beat_s1.last_byte    <= rx.last_byte;
			beat_s1.link_quality <= rx.link_quality;
		end
	end

	mhp_parse #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.beat   (beat_s1),
		.res    (pr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= adv_s1 && pr.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pr.emit) begin
			res_q <= pr.fields;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.item_kind     = res_q.item_kind;
	assign res.fc_type       = res_q.fc_type;
	assign res.dst_addr_mode = res_q.dst_addr_mode;
	assign res.src_addr_mode = res_q.src_addr_mode;
	assign res.control_flags = res_q.control_flags;
	assign res.dest_pan      = res_q.dest_pan;
	assign res.dest_addr     = res_q.dest_addr;
	assign res.source_pan    = res_q.source_pan;
	assign res.source_addr   = res_q.source_addr;
	assign res.payload_byte  = res_q.payload_byte;
	assign res.frame_end     = res_q.frame_end;
	assign res.quality_out   = res_q.quality_out;

endmodule

FILE: sv/mhp_parse.sv
// Per-frame parse state and the next-state logic for one frame byte.
// Depends on mhp_pkg; instantiated by mac_header_parser.
module mhp_parse #(
	parameter int MAX_FRAME_BYTES = mhp_pkg::MHP_MAX_FRAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  mhp_pkg::beat_t      beat,
	output mhp_pkg::parse_res_t res
);
	import mhp_pkg::*;

	logic [IDX_W-1:0] idx_q, idx_n;
	logic [15:0]      cw_q, cw_base, cw_n;
	logic [15:0]      dpan_q, dpan_base, dpan_n;
	logic [63:0]      daddr_q, daddr_base, daddr_n;
	logic [15:0]      span_q, span_base, span_n;
	logic [63:0]      saddr_q, saddr_base, saddr_n;
	logic [HL_W-1:0]  hl_q, hl_base, hl_n;
	logic [7:0]       qual_q, qual_n;

	logic             first, in_limit, in_addr, last;
	logic [7:0]       b;
	sizes_t           sz_new, sz_cur;
	logic [4:0]       off, off2, off3, off4;
	logic [IDX_W:0]   p_plus1;
	logic             emit;
	kind_t            kind;

	assign b     = beat.data_byte;
	assign last  = beat.last_byte;
	assign first = (idx_q == '0);
	assign in_limit = int'(idx_q) < MAX_FRAME_BYTES;

	// The first byte of a frame starts from a cleared header.
	assign cw_base    = first ? '0 : cw_q;
	assign dpan_base  = first ? '0 : dpan_q;
	assign daddr_base = first ? '0 : daddr_q;
	assign span_base  = first ? '0 : span_q;
	assign saddr_base = first ? '0 : saddr_q;
	assign hl_base    = first ? '0 : hl_q;
	assign qual_n     = first ? beat.link_quality : qual_q;

	always_comb begin
		cw_n = cw_base;
		if (in_limit && first) begin
			cw_n = {8'h00, b};
		end else if (in_limit && idx_q == 7'd1) begin
			cw_n = {b, cw_base[7:0]};
		end
	end

	assign sz_new = field_sizes(cw_n);
	assign sz_cur = field_sizes(cw_base);

	assign hl_n = (in_limit && idx_q == 7'd1)
		? BASE_HDR_BYTES + 5'(sz_new.dp) + 5'(sz_new.dl) + 5'(sz_new.sp) + 5'(sz_new.sl)
		: hl_base;

	// Addressing bytes: offset past the sequence number, walked field by field.
	assign in_addr = in_limit && idx_q >= 7'd3 && idx_q < {2'b00, hl_base};
	assign off  = idx_q[4:0] - 5'd3;
	assign off2 = off - 5'(sz_cur.dp);
	assign off3 = off2 - 5'(sz_cur.dl);
	assign off4 = off3 - 5'(sz_cur.sp);

	always_comb begin
		dpan_n  = dpan_base;
		daddr_n = daddr_base;
		span_n  = span_base;
		saddr_n = saddr_base;
		if (in_addr) begin
			priority if (off < 5'(sz_cur.dp)) begin
				dpan_n[8*off[0] +: 8] = dpan_base[8*off[0] +: 8] | b;
			end else if (off2 < 5'(sz_cur.dl)) begin
				daddr_n[8*off2[2:0] +: 8] = daddr_base[8*off2[2:0] +: 8] | b;
			end else if (off3 < 5'(sz_cur.sp)) begin
				span_n[8*off3[0] +: 8] = span_base[8*off3[0] +: 8] | b;
			end else if (off4 < 5'(sz_cur.sl)) begin
				saddr_n[8*off4[2:0] +: 8] = saddr_base[8*off4[2:0] +: 8] | b;
			end
		end
	end

	assign p_plus1 = {1'b0, idx_q} + 8'd1;

	always_comb begin
		emit = 1'b0;
		kind = KIND_SHORT;
		if (idx_q < 7'd2 || p_plus1 < {3'b000, hl_n}) begin
			emit = last;
			kind = KIND_SHORT;
		end else if (p_plus1 == {3'b000, hl_n}) begin
			emit = in_limit || last;
			kind = in_limit ? KIND_HEADER : KIND_SHORT;
		end else begin
			emit = in_limit || last;
			if (in_limit || int'(hl_n) <= MAX_FRAME_BYTES) begin
				kind = KIND_PAYLOAD;
			end else begin
				kind = KIND_SHORT;
			end
		end
	end

	always_comb begin
		idx_n = idx_q;
		if (last) begin
			idx_n = '0;
		end else if (idx_q < IDX_SAT) begin
			idx_n = idx_q + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			cw_q    <= '0;
			dpan_q  <= '0;
			daddr_q <= '0;
			span_q  <= '0;
			saddr_q <= '0;
			hl_q    <= '0;
			qual_q  <= '0;
		end else if (step) begin
			idx_q   <= idx_n;
			cw_q    <= cw_n;
			dpan_q  <= dpan_n;
			daddr_q <= daddr_n;
			span_q  <= span_n;
			saddr_q <= saddr_n;
			hl_q    <= hl_n;
			qual_q  <= qual_n;
		end
	end

	always_comb begin
		res.emit                 = emit;
		res.fields.item_kind     = kind;
		res.fields.fc_type       = cw_n[2:0];
		res.fields.dst_addr_mode = cw_n[11:10];
		res.fields.src_addr_mode = cw_n[15:14];
		res.fields.control_flags = {cw_n[13:12], cw_n[6:3]};
		res.fields.dest_pan      = dpan_n;
		res.fields.dest_addr     = daddr_n;
		res.fields.source_pan    = span_n;
		res.fields.source_addr   = saddr_n;
		res.fields.payload_byte  = (kind == KIND_PAYLOAD) ? b : 8'h00;
		res.fields.frame_end     = last;
		res.fields.quality_out   = qual_n;
	end

endmodule

FILE: sv/mhp_checker.sv
// Port-level assertions for the MAC header parser, attached by the bind below.
// Depends on mhp_pkg and mac_header_parser.
module mhp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  item_kind,
	input logic [1:0]  dst_addr_mode,
	input logic [15:0] dest_pan,
	input logic [63:0] dest_addr,
	input logic [7:0]  payload_byte,
	input logic        frame_end
);
	import mhp_pkg::*;

	// A stalled result beat keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(item_kind) && $stable(payload_byte)
			&& $stable(frame_end))
		else $error("result beat changed while stalled");

	// A new result needs a byte that was accepted and then passed the input register.
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
		else $error("result appeared without an accepted byte");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && item_kind != KIND_PAYLOAD |-> payload_byte == 8'h00)
		else $error("payload byte set on a non-payload result");

	// Without a destination address no destination field may be filled.
	a_dest_absent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && item_kind == KIND_HEADER && dst_addr_mode != AM_SHORT
			&& dst_addr_mode != AM_EXT
			|-> dest_pan == 16'h0000 && dest_addr == 64'h0)
		else $error("destination field filled although absent");

endmodule

bind mac_header_parser mhp_checker u_mhp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx.valid),
	.rx_ready      (rx.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.item_kind     (res.item_kind),
	.dst_addr_mode (res.dst_addr_mode),
	.dest_pan      (res.dest_pan),
	.dest_addr     (res.dest_addr),
	.payload_byte  (res.payload_byte),
	.frame_end     (res.frame_end)
);
